[hdl/itlf_pkg.sv]
// Package for the sensor text line framer: character codes, default sizes and
// the result type passed from the readout sequencer to the top level.
// No dependencies.
package itlf_pkg;

  localparam int unsigned DefBufferDepth = 64;

  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChStar = 8'h2A;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_empty;
    logic       not_forwarded;
    logic       last;
  } itlf_result_t;

endpackage

[hdl/itlf_store.sv]
// Line store: single-port-write, single-port-read synchronous memory with a
// registered read port. Depends on nothing beyond its parameters.
module itlf_store #(
  parameter int unsigned BUFFER_DEPTH = 64,
  localparam int unsigned Aw = $clog2(BUFFER_DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [Aw-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [Aw-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // The read data holds between reads, so a stalled evaluation sees it again.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/itlf_reader.sv]
// Readout sequencer: walks the line store from position zero at a line end and
// drives the registered result stage. Depends on itlf_pkg.
module itlf_reader import itlf_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 64,
  localparam int unsigned Aw = $clog2(BUFFER_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [Aw-1:0] len_i,
  input  logic          en_i,
  output logic          busy_o,
  output logic          rd_en_o,
  output logic [Aw-1:0] rd_addr_o,
  input  logic [7:0]    rd_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output itlf_result_t  out_res_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StEval  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [Aw-1:0] idx_q, idx_d;
  logic [Aw-1:0] len_q, len_d;
  logic          en_q, en_d;
  logic [7:0]    pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  itlf_result_t  res_q, res_d;
  logic          out_free, is_end, emit;

  assign out_free = !out_valid_q || !out_stall_i;
  // The run stops at the write position or before the first zero byte.
  assign is_end   = (idx_q == len_q) || (rd_data_i == 8'h00);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    len_d   = len_q;
    en_d    = en_q;
    pend_d  = pend_q;
    emit    = 1'b0;
    res_d   = res_q;
    rd_en_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          idx_d   = '0;
          len_d   = len_i;
          en_d    = en_i;
          state_d = StIssue;
        end
      end
      StIssue: begin
        rd_en_o = 1'b1;
        state_d = StEval;
      end
      StEval: begin
        if (idx_q == '0) begin
          if (is_end || !en_q) begin
            if (out_free) begin
              emit    = 1'b1;
              res_d   = '{line_byte: 8'h00, line_empty: is_end,
                          not_forwarded: !en_q, last: 1'b1};
              state_d = StIdle;
            end
          end else begin
            pend_d  = rd_data_i;
            idx_d   = idx_q + Aw'(1);
            state_d = StIssue;
          end
        end else if (out_free) begin
          emit   = 1'b1;
          res_d  = '{line_byte: pend_q, line_empty: 1'b0,
                     not_forwarded: 1'b0, last: is_end};
          if (is_end) begin
            state_d = StIdle;
          end else begin
            pend_d  = rd_data_i;
            idx_d   = idx_q + Aw'(1);
            state_d = StIssue;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    out_valid_d = emit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    len_q  <= len_d;
    en_q   <= en_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  assign busy_o      = (state_q != StIdle);
  assign rd_addr_o   = idx_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

[hdl/imu_text_line_framer.sv]
// Top level of the sensor text line framer: write position, configuration
// register, line store and readout sequencer. Depends on itlf_pkg,
// itlf_store and itlf_reader.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o   rx_byte_i
//   out      output     out_valid_o / out_stall_i line_byte_o, line_empty_o,
//                                                 not_forwarded_o, last_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_measure_enable_i
//
// A byte other than a line feed is taken without starting a readout and gives no result.
// A line feed starts a readout that alternates a memory read and an
// evaluation for each stored byte, since the single read port of the line
// store is walked one entry at a time; an empty or report-only line gives
// a single result from the first evaluation.
// Input stays stalled during the readout and is taken again as soon as the
// final result sits in the output register. Output stalls freeze the walk.
// Reset clears the write position, the enable and the control state; the
// store itself is not cleared.
module imu_text_line_framer import itlf_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = DefBufferDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] line_byte_o,
  output logic       line_empty_o,
  output logic       not_forwarded_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_measure_enable_i
);

  localparam int unsigned Aw = $clog2(BUFFER_DEPTH);

  logic [Aw-1:0] wpos_q, wpos_d;
  logic          meas_en_q;
  logic          in_xfer, busy, rd_en;
  logic [Aw-1:0] rd_addr;
  logic [7:0]    rd_data;
  itlf_result_t  res;

  assign in_xfer     = in_valid_i && !in_stall_o;
  assign in_stall_o  = busy;
  assign cfg_ready_o = 1'b1;

  // A restart or a line end returns to position zero, a carriage return
  // leaves the position alone, and every other byte advances it with wrap.
  always_comb begin
    wpos_d = wpos_q;
    if (in_xfer) begin
      if (rx_byte_i == ChLf || rx_byte_i == ChStar) begin
        wpos_d = '0;
      end else if (rx_byte_i != ChCr) begin
        wpos_d = (wpos_q == Aw'(BUFFER_DEPTH - 1)) ? '0 : wpos_q + Aw'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q    <= '0;
      meas_en_q <= 1'b0;
    end else begin
      wpos_q <= wpos_d;
      if (cfg_valid_i && cfg_ready_o) begin
        meas_en_q <= cfg_measure_enable_i;
      end
    end
  end

  // Every accepted byte, the line feed included, lands at the write position.
  itlf_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (in_xfer),
    .wr_addr_i(wpos_q),
    .wr_data_i(rx_byte_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // The readout covers positions below the write position held at the line
  // feed; writes cannot occur while it runs because input is stalled.
  itlf_reader #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_reader (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer && (rx_byte_i == ChLf)),
    .len_i      (wpos_q),
    .en_i       (meas_en_q),
    .busy_o     (busy),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (res)
  );

  assign line_byte_o     = res.line_byte;
  assign line_empty_o    = res.line_empty;
  assign not_forwarded_o = res.not_forwarded;
  assign last_o          = res.last;

endmodule

[hdl/itlf_checker.sv]
// Port-level checker for the sensor text line framer and its bind to the top
// level. Depends on itlf_pkg.
module itlf_checker import itlf_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] rx_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] line_byte_o,
  input logic       line_empty_o,
  input logic       not_forwarded_o,
  input logic       last_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_byte_o)
      && $stable(last_o) && $stable(line_empty_o) && $stable(not_forwarded_o))
    else $error("stalled result changed");

  a_empty_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (line_empty_o || not_forwarded_o) |-> last_o && (line_byte_o == 8'h00))
    else $error("empty or unforwarded result is not a lone zero result");

  a_run_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input taken in the middle of a run");

  a_lf_starts_readout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (rx_byte_i == ChLf) |=> in_stall_o)
    else $error("line feed did not start a readout");

  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind imu_text_line_framer itlf_checker u_itlf_checker (.*);

[bench/imu_text_line_framer_tb.sv]
// Self-checking testbench for imu_text_line_framer: drives received bytes and
// configuration writes, predicts every line readout and compares it on output.
// Depends on itlf_pkg and the imu_text_line_framer RTL.
module imu_text_line_framer_tb;
  import itlf_pkg::*;

  localparam int unsigned BufDepth     = DefBufferDepth;
  // Idle cycles after the last result before the register is touched; a
  // byte that gives no result is absorbed without starting a readout.
  localparam int unsigned SettleCycles = 20;
  // Length of the long output hold used to fill the block up.
  localparam int unsigned HoldCycles   = 400;
  // Generous end of run, far above the slowest correct run.
  localparam longint      RunLimit     = 64'd3_000_000;

  logic       clk_i;
  logic       rst_ni               = 1'b0;
  logic       in_valid_i           = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i            = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i          = 1'b0;
  logic [7:0] line_byte_o;
  logic       line_empty_o;
  logic       not_forwarded_o;
  logic       last_o;
  logic       cfg_valid_i          = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_measure_enable_i = 1'b0;

  imu_text_line_framer dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .rx_byte_i           (rx_byte_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .line_byte_o         (line_byte_o),
    .line_empty_o        (line_empty_o),
    .not_forwarded_o     (not_forwarded_o),
    .last_o              (last_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_measure_enable_i(cfg_measure_enable_i)
  );

  // Shadow copy of the framer state, kept in step with accepted transfers.
  logic [7:0]   line_mem [BufDepth];
  logic [5:0]   wr_pos;
  logic         measure_en;

  // Line readout results still owed by the block, oldest first.
  itlf_result_t pending_readout [$];
  itlf_result_t want_r;

  int           error_count = 0;
  int           bytes_sent  = 0;

  // Idling controls. The sender gaps and the receiver stalls at random unless
  // the matching flag is cleared; hold_left forces a long output stall.
  bit           tx_idle_on  = 1'b1;
  bit           rx_idle_on  = 1'b1;
  int           hold_left   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(RunLimit);
    $display("imu_text_line_framer_tb NOT OK");
    $finish;
  end

  function automatic itlf_result_t make_result(logic [7:0] b, logic empty, logic nf,
                                               logic fin);
    itlf_result_t r;
    r.line_byte     = b;
    r.line_empty    = empty;
    r.not_forwarded = nf;
    r.last          = fin;
    return r;
  endfunction

  // Applies one accepted byte to the shadow state. A line feed queues the
  // readout that the block owes for the line it closes.
  function automatic void frame_byte(logic [7:0] b);
    int pos;
    int len;
    pos = wr_pos;
    if (pos >= BufDepth) pos = 0;
    line_mem[pos] = b;
    if (b == ChLf) begin
      // The line stops short at the first zero byte.
      len = 0;
      while (len < pos && line_mem[len] != 8'h00) len++;
      wr_pos = '0;
      if (!measure_en) begin
        pending_readout.push_back(make_result(8'h00, len == 0, 1'b1, 1'b1));
      end else if (len == 0) begin
        pending_readout.push_back(make_result(8'h00, 1'b1, 1'b0, 1'b1));
      end else begin
        for (int i = 0; i < len; i++) begin
          pending_readout.push_back(make_result(line_mem[i], 1'b0, 1'b0, i == len - 1));
        end
      end
    end else if (b == ChStar) begin
      wr_pos = '0;
    end else if (b != ChCr) begin
      pos++;
      if (pos >= BufDepth) pos = 0;
      wr_pos = pos[5:0];
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    if (error_count <= 20) begin
      $display("mismatch: %s got %0d expected %0d (outstanding %0d)", what, got, want,
               pending_readout.size());
    end
  endtask

  // Output monitor. Ports are sampled at the rising edge, before any
  // nonblocking update of that edge lands.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readout.size() == 0) begin
        report_mismatch("result with nothing outstanding, line_byte", line_byte_o, 0);
      end else begin
        want_r = pending_readout.pop_front();
        if (line_byte_o !== want_r.line_byte)
          report_mismatch("line_byte", line_byte_o, want_r.line_byte);
        if (line_empty_o !== want_r.line_empty)
          report_mismatch("line_empty", line_empty_o, want_r.line_empty);
        if (not_forwarded_o !== want_r.not_forwarded)
          report_mismatch("not_forwarded", not_forwarded_o, want_r.not_forwarded);
        if (last_o !== want_r.last)
          report_mismatch("last", last_o, want_r.last);
      end
    end
  end

  // Receiver side. A pending hold wins over everything; otherwise the
  // receiver stalls at random, with odds of 12 in a hundred, while idling is on.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (!rx_idle_on) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 12);
    end
  end

  // Sends one byte and returns at the edge that completes its transfer.
  // Valid is only lowered for a gap and never dropped and raised in one step.
  task automatic send_byte(logic [7:0] b);
    while (tx_idle_on && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    frame_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Stops offering bytes, waits for every owed result and lets the readout
  // sequencer settle, so that the block is idle afterwards.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_readout.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_measure(logic value);
    wait_idle();
    cfg_valid_i          <= 1'b1;
    cfg_measure_enable_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    measure_en = value;
  endtask

  function automatic logic [7:0] printable_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(126, 32)); while (b == ChStar);
    return b;
  endfunction

  // One line of random content closed by a line feed. Most bytes are plain
  // text; the rest are carriage returns, restarts, zero bytes and noise.
  task automatic send_random_line();
    int len;
    int pick;
    len = ($urandom_range(9) == 0) ? $urandom_range(24, 16) : $urandom_range(6);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 80)      send_byte(printable_byte());
      else if (pick < 87) send_byte(ChCr);
      else if (pick < 91) send_byte(ChStar);
      else if (pick < 94) send_byte(8'h00);
      else                send_byte(8'($urandom_range(255)));
    end
    send_byte(ChLf);
  endtask

  // With measurement off each line is only reported, empty or not.
  task automatic test_report_only();
    write_measure(1'b0);
    send_text("AB");
    send_byte(ChLf);
    send_byte(ChLf);
  endtask

  // Byte extremes go out unchanged, a carriage return is dropped and an
  // empty line is flagged as such.
  task automatic test_forward_extremes();
    write_measure(1'b1);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(ChCr);
    send_byte(8'h7F);
    send_byte(ChLf);
    send_byte(ChLf);
  endtask

  // A star restarts the line; a zero byte cuts the line short, and a line
  // that starts with one counts as empty.
  task automatic test_restart_and_zero();
    send_text("X*Y");
    send_byte(ChLf);
    send_byte(8'h00);
    send_text("A");
    send_byte(ChLf);
    send_text("A");
    send_byte(8'h00);
    send_text("B");
    send_byte(ChLf);
  endtask

  // More bytes than the store holds: the write position wraps and the first
  // entries are overwritten. Run without any idling on either side.
  task automatic test_buffer_wrap();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int i = 0; i < BufDepth + 2; i++) send_byte(printable_byte());
    send_byte(ChLf);
    wait_idle();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while lines keep coming, so
  // the output register fills and the input stalls. Afterwards the sender
  // pauses until the whole backlog has drained.
  task automatic test_output_backpressure();
    hold_left = HoldCycles;
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 3; i++) send_byte(printable_byte());
      send_byte(ChLf);
    end
    wait_idle();
  endtask

  // Random lines in three phases: reporting only, forwarding, and a random
  // setting of the enable.
  task automatic test_random_lines();
    int start;
    logic [2:0] phase_cfg;
    phase_cfg = {$urandom_range(1) == 1, 1'b1, 1'b0};
    for (int p = 0; p < 3; p++) begin
      write_measure(phase_cfg[p]);
      start = bytes_sent;
      while (bytes_sent - start < 4) send_random_line();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Mirror of the reset state; the store content is never read unwritten.
    for (int i = 0; i < BufDepth; i++) line_mem[i] = 8'h00;
    wr_pos     = '0;
    measure_en = 1'b0;

    test_report_only();
    test_forward_extremes();
    test_restart_and_zero();
    test_buffer_wrap();
    test_output_backpressure();
    test_random_lines();

    wait_idle();
    repeat (4 * BufDepth) @(posedge clk_i);
    if (error_count == 0 && pending_readout.size() == 0) begin
      $display("imu_text_line_framer_tb OK");
    end else begin
      $display("imu_text_line_framer_tb NOT OK");
    end
    $finish;
  end

endmodule
